FILE: hw/rtl/tlt_pkg.sv
package tlt_pkg;

   localparam int KIND_BITS   = 5;
   localparam int CHAR_BITS   = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_END        = 5'd0,
      KIND_LPAREN     = 5'd1,
      KIND_RPAREN     = 5'd2,
      KIND_NOT        = 5'd3,
      KIND_NEXT       = 5'd4,
      KIND_ALWAYS     = 5'd5,
      KIND_EVENTUALLY = 5'd6,
      KIND_UNTIL      = 5'd7,
      KIND_WEAK_UNTIL = 5'd8,
      KIND_RELEASE    = 5'd9,
      KIND_AND        = 5'd10,
      KIND_OR         = 5'd11,
      KIND_IMPLIES    = 5'd12,
      KIND_TRUE       = 5'd13,
      KIND_FALSE      = 5'd14,
      KIND_IDENT      = 5'd15,
      KIND_ERROR      = 5'd16
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_BSLASH = 3'd2,
      MODE_MINUS  = 3'd3,
      MODE_IDENT  = 3'd4,
      MODE_ERROR  = 3'd5
   } scan_mode_type;

   typedef enum logic [1:0] {
      KW_NONE  = 2'd0,
      KW_TRUE  = 2'd1,
      KW_FALSE = 2'd2
   } keyword_type;

   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_VT     = 8'h0B;
   localparam logic [CHAR_BITS-1:0] CH_FF     = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_BITS-1:0] CH_X      = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_G      = 8'h47;
   localparam logic [CHAR_BITS-1:0] CH_F      = 8'h46;
   localparam logic [CHAR_BITS-1:0] CH_U      = 8'h55;
   localparam logic [CHAR_BITS-1:0] CH_W      = 8'h57;
   localparam logic [CHAR_BITS-1:0] CH_R      = 8'h52;
   localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_BITS-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOW_Z  = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_LOW_T  = 8'h74;
   localparam logic [CHAR_BITS-1:0] CH_LOW_F  = 8'h66;

   localparam int TRUE_LEN  = 4;
   localparam int FALSE_LEN = 5;

   // letters of the keyword "true"
   function automatic logic [CHAR_BITS-1:0] true_char(input logic [1:0] idx);
      logic [CHAR_BITS-1:0] ch;
      unique case (idx)
         2'd0: ch = 8'h74;
         2'd1: ch = 8'h72;
         2'd2: ch = 8'h75;
         default: ch = 8'h65;
      endcase
      return ch;
   endfunction

   // letters of the keyword "false"; index 5 and up never reaches here
   function automatic logic [CHAR_BITS-1:0] false_char(input logic [2:0] idx);
      logic [CHAR_BITS-1:0] ch;
      unique case (idx)
         3'd0: ch = 8'h66;
         3'd1: ch = 8'h61;
         3'd2: ch = 8'h6C;
         3'd3: ch = 8'h73;
         default: ch = 8'h65;
      endcase
      return ch;
   endfunction

   function automatic logic is_word_char(input logic [CHAR_BITS-1:0] ch);
      return ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) || ((ch >= CH_ZERO) && (ch <= CH_NINE));
   endfunction

endpackage

FILE: hw/rtl/tlt_req_if.sv
interface tlt_req_if import tlt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

FILE: hw/rtl/tlt_rsp_if.sv
interface tlt_rsp_if import tlt_pkg::*; #(
   parameter int POS_BITS = 16,
   parameter int LEN_BITS = 8
) ();
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] token_kind;
   logic [POS_BITS-1:0]  start_position;
   logic [LEN_BITS-1:0]  ident_length;
   logic                 last_of_run;

   modport source (
      output valid, output token_kind, output start_position,
      output ident_length, output last_of_run, input ready
   );
   modport sink (
      input valid, input token_kind, input start_position,
      input ident_length, input last_of_run, output ready
   );
endinterface

FILE: hw/rtl/temporal_logic_tokenizer.sv
// Temporal-logic tokenizer: scans a formula one byte per beat and emits tokens.
// req_bus (sink): char_code plus end_of_input; end_of_input flushes any pending
//   token, emits End and returns the scanner to its reset state (position 0).
// rsp_bus (source): token_kind, start_position, ident_length, last_of_run.
//   A request beat yields zero, one or two response beats; last_of_run marks
//   the final one of each request.
// A token enters the queue with the request beat that settles it and reaches
//   rsp_bus after the entries ahead of it. Throughput: one request beat per cycle
//   while req_bus.ready is high; a four-entry queue yields one response per ready cycle.
// req_bus.ready is high while the queue holds at most two entries, so a request
//   that makes two tokens always fits. A rare two-token request stalls the next
//   request only if the queue has not drained.
// When the receiver stalls, responses hold in the queue; once it holds three or
//   more, req_bus.ready drops until rsp_bus drains it back to two entries.
// Reset (synchronous, active high): empties the queue and clears the scanner
//   state to idle at position 0.
module temporal_logic_tokenizer import tlt_pkg::*; #(
   parameter int POS_BITS = 16,
   parameter int LEN_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   tlt_req_if.sink    req_bus,
   tlt_rsp_if.source  rsp_bus
);

   localparam logic [POS_BITS-1:0] POS_MAX = '1;
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   // scanner state
   logic [POS_BITS-1:0] char_position_ff, char_position_in;
   scan_mode_type       scan_mode_ff, scan_mode_in;
   logic [POS_BITS-1:0] ident_start_ff, ident_start_in;
   logic [LEN_BITS-1:0] ident_count_ff, ident_count_in;
   keyword_type         keyword_match_ff, keyword_match_in;

   // response queue, head at entry 0
   logic [KIND_BITS-1:0]  q_kind_ff [QUEUE_DEPTH];
   logic [POS_BITS-1:0]   q_pos_ff  [QUEUE_DEPTH];
   logic [LEN_BITS-1:0]   q_len_ff  [QUEUE_DEPTH];
   logic                  q_last_ff [QUEUE_DEPTH];
   logic [KIND_BITS-1:0]  q_kind_in [QUEUE_DEPTH];
   logic [POS_BITS-1:0]   q_pos_in  [QUEUE_DEPTH];
   logic [LEN_BITS-1:0]   q_len_in  [QUEUE_DEPTH];
   logic                  q_last_in [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic req_take;
   logic rsp_take;

   // tokens made by the current beat
   logic                 a_valid, b_valid;
   kind_type             a_kind, b_kind;
   logic [POS_BITS-1:0]  a_pos;
   logic [LEN_BITS-1:0]  a_len;

   // what an idle-state character does
   logic                 ic_emit;
   kind_type             ic_kind;
   scan_mode_type        ic_mode;
   logic                 ic_start;
   logic                 ic_word;
   logic [CHAR_BITS-1:0] ch;
   kind_type             flush_kind;
   kind_type             op_kind;
   logic [CHAR_BITS-1:0] op_want;
   keyword_type          kw_ext;
   logic [LEN_BITS-1:0]  count_ext;

   assign ch       = req_bus.char_code;
   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   // room for two tokens is kept free before a beat is taken
   assign req_bus.ready = (count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2));

   assign rsp_bus.valid          = (count_ff != '0);
   assign rsp_bus.token_kind     = q_kind_ff[0];
   assign rsp_bus.start_position = q_pos_ff[0];
   assign rsp_bus.ident_length   = q_len_ff[0];
   assign rsp_bus.last_of_run    = q_last_ff[0];

   // classify a character seen from the idle state
   always_comb begin
      ic_emit  = 1'b0;
      ic_kind  = KIND_ERROR;
      ic_mode  = MODE_IDLE;
      ic_start = 1'b0;
      ic_word  = 1'b0;
      priority case (ch)
         CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ic_emit = 1'b0;
         CH_LPAREN: begin ic_emit = 1'b1; ic_kind = KIND_LPAREN;     end
         CH_RPAREN: begin ic_emit = 1'b1; ic_kind = KIND_RPAREN;     end
         CH_BANG:   begin ic_emit = 1'b1; ic_kind = KIND_NOT;        end
         CH_X:      begin ic_emit = 1'b1; ic_kind = KIND_NEXT;       end
         CH_G:      begin ic_emit = 1'b1; ic_kind = KIND_ALWAYS;     end
         CH_F:      begin ic_emit = 1'b1; ic_kind = KIND_EVENTUALLY; end
         CH_U:      begin ic_emit = 1'b1; ic_kind = KIND_UNTIL;      end
         CH_W:      begin ic_emit = 1'b1; ic_kind = KIND_WEAK_UNTIL; end
         CH_R:      begin ic_emit = 1'b1; ic_kind = KIND_RELEASE;    end
         CH_SLASH:  begin ic_mode = MODE_SLASH;  ic_start = 1'b1; end
         CH_BSLASH: begin ic_mode = MODE_BSLASH; ic_start = 1'b1; end
         CH_MINUS:  begin ic_mode = MODE_MINUS;  ic_start = 1'b1; end
         default: begin
            if (is_word_char(ch)) begin
               ic_mode  = MODE_IDENT;
               ic_start = 1'b1;
               ic_word  = 1'b1;
            end else begin
               ic_emit = 1'b1;
               ic_kind = KIND_ERROR;
               ic_mode = MODE_ERROR;
            end
         end
      endcase
   end

   // keyword tracking when a word character extends the pending identifier
   always_comb begin
      kw_ext = keyword_match_ff;
      if (keyword_match_ff == KW_TRUE) begin
         if ((ident_count_ff >= LEN_BITS'(TRUE_LEN)) ||
             (ch != true_char(ident_count_ff[1:0])))
            kw_ext = KW_NONE;
      end else if (keyword_match_ff == KW_FALSE) begin
         if ((ident_count_ff >= LEN_BITS'(FALSE_LEN)) ||
             (ch != false_char(ident_count_ff[2:0])))
            kw_ext = KW_NONE;
      end
      count_ext = (ident_count_ff == LEN_MAX) ? ident_count_ff
                                              : ident_count_ff + LEN_BITS'(1);
   end

   always_comb begin
      flush_kind = KIND_IDENT;
      if ((keyword_match_ff == KW_TRUE) && (ident_count_ff == LEN_BITS'(TRUE_LEN)))
         flush_kind = KIND_TRUE;
      else if ((keyword_match_ff == KW_FALSE) &&
               (ident_count_ff == LEN_BITS'(FALSE_LEN)))
         flush_kind = KIND_FALSE;
   end

   always_comb begin
      unique case (scan_mode_ff)
         MODE_SLASH:  begin op_want = CH_BSLASH; op_kind = KIND_AND;     end
         MODE_BSLASH: begin op_want = CH_SLASH;  op_kind = KIND_OR;      end
         default:     begin op_want = CH_GT;     op_kind = KIND_IMPLIES; end
      endcase
   end

   // scanner next state and tokens of this beat
   always_comb begin
      char_position_in = char_position_ff;
      scan_mode_in     = scan_mode_ff;
      ident_start_in   = ident_start_ff;
      ident_count_in   = ident_count_ff;
      keyword_match_in = keyword_match_ff;
      a_valid = 1'b0;
      a_kind  = KIND_END;
      a_pos   = char_position_ff;
      a_len   = '0;
      b_valid = 1'b0;
      b_kind  = KIND_END;

      if (req_bus.end_of_input) begin
         // flush, emit End, back to reset state
         unique case (scan_mode_ff)
            MODE_IDENT: begin
               a_valid = 1'b1;
               a_kind  = flush_kind;
               a_pos   = ident_start_ff;
               a_len   = ident_count_ff;
               b_valid = 1'b1;
            end
            MODE_SLASH, MODE_BSLASH, MODE_MINUS: begin
               a_valid = 1'b1;
               a_kind  = KIND_ERROR;
               a_pos   = ident_start_ff;
               b_valid = 1'b1;
            end
            default: begin
               a_valid = 1'b1;
               a_kind  = KIND_END;
            end
         endcase
         char_position_in = '0;
         scan_mode_in     = MODE_IDLE;
         ident_start_in   = '0;
         ident_count_in   = '0;
         keyword_match_in = KW_NONE;
      end else begin
         unique case (scan_mode_ff)
            MODE_ERROR: begin
               // drop everything until end of input
            end
            MODE_SLASH, MODE_BSLASH, MODE_MINUS: begin
               a_valid = 1'b1;
               a_pos   = ident_start_ff;
               if (ch == op_want) begin
                  a_kind       = op_kind;
                  scan_mode_in = MODE_IDLE;
               end else begin
                  a_kind       = KIND_ERROR;
                  scan_mode_in = MODE_ERROR;
               end
            end
            MODE_IDENT: begin
               if (is_word_char(ch)) begin
                  keyword_match_in = kw_ext;
                  ident_count_in   = count_ext;
               end else begin
                  // emit the identifier, then treat the character as at idle
                  a_valid      = 1'b1;
                  a_kind       = flush_kind;
                  a_pos        = ident_start_ff;
                  a_len        = ident_count_ff;
                  b_valid      = ic_emit;
                  b_kind       = ic_kind;
                  scan_mode_in = ic_mode;
                  if (ic_start) ident_start_in = char_position_ff;
               end
            end
            default: begin
               a_valid      = ic_emit;
               a_kind       = ic_kind;
               scan_mode_in = ic_mode;
               if (ic_start) ident_start_in = char_position_ff;
               if (ic_word) begin
                  ident_count_in   = LEN_BITS'(1);
                  keyword_match_in = (ch == CH_LOW_T) ? KW_TRUE :
                                     (ch == CH_LOW_F) ? KW_FALSE : KW_NONE;
               end
            end
         endcase
         if (char_position_ff != POS_MAX)
            char_position_in = char_position_ff + POS_BITS'(1);
      end
   end

   // queue update: shift out the head, then append the new tokens
   always_comb begin
      logic [COUNT_BITS-1:0] base;
      logic                  push_a;
      logic                  push_b;
      base   = count_ff - COUNT_BITS'(rsp_take);
      push_a = req_take && a_valid;
      push_b = req_take && b_valid;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (rsp_take && (i < QUEUE_DEPTH - 1)) begin
            q_kind_in[i] = q_kind_ff[(i + 1) % QUEUE_DEPTH];
            q_pos_in[i]  = q_pos_ff[(i + 1) % QUEUE_DEPTH];
            q_len_in[i]  = q_len_ff[(i + 1) % QUEUE_DEPTH];
            q_last_in[i] = q_last_ff[(i + 1) % QUEUE_DEPTH];
         end else begin
            q_kind_in[i] = q_kind_ff[i];
            q_pos_in[i]  = q_pos_ff[i];
            q_len_in[i]  = q_len_ff[i];
            q_last_in[i] = q_last_ff[i];
         end
         if (push_a && (base == COUNT_BITS'(i))) begin
            q_kind_in[i] = a_kind;
            q_pos_in[i]  = a_pos;
            q_len_in[i]  = a_len;
            q_last_in[i] = !b_valid;
         end
         if (push_b && (base + COUNT_BITS'(1) == COUNT_BITS'(i))) begin
            q_kind_in[i] = b_kind;
            q_pos_in[i]  = char_position_ff;
            q_len_in[i]  = '0;
            q_last_in[i] = 1'b1;
         end
      end
      count_in = base + COUNT_BITS'(push_a) + COUNT_BITS'(push_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         char_position_ff <= '0;
         scan_mode_ff     <= MODE_IDLE;
         ident_start_ff   <= '0;
         ident_count_ff   <= '0;
         keyword_match_ff <= KW_NONE;
      end else begin
         count_ff <= count_in;
         if (req_take) begin
            char_position_ff <= char_position_in;
            scan_mode_ff     <= scan_mode_in;
            ident_start_ff   <= ident_start_in;
            ident_count_ff   <= ident_count_in;
            keyword_match_ff <= keyword_match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_kind_ff[i] <= q_kind_in[i];
         q_pos_ff[i]  <= q_pos_in[i];
         q_len_ff[i]  <= q_len_in[i];
         q_last_ff[i] <= q_last_in[i];
      end
   end

endmodule
